@@ design/client_table_fanout_aging_assert.svh @@
// Assertion macros for the client table fan-out block.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef CLIENT_TABLE_FANOUT_AGING_ASSERT_SVH
`define CLIENT_TABLE_FANOUT_AGING_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define CTA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define CTA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/cta_pkg.sv @@
// Shared types and constants for the client table fan-out block.
// No dependencies; imported by every module of the block.
package cta_pkg;

	localparam int ADDR_W      = 32;
	localparam int LIFE_W      = 16;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = 6;
	localparam logic [LIFE_W-1:0] LIFETIME_AT_RESET = 16'd1000;

	// One table slot: address (zero means empty) and remaining lifetime
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LIFE_W-1:0] life;
	} entry_t;

	// Result of processing the slot at the head of the ring
	typedef struct packed {
		entry_t nxt;
		logic   emit;
		logic   ins;
	} head_res_t;

endpackage

@@ design/client_table_fanout_aging.sv @@
// Top level of the client table fan-out block: ring of cells, control, output stage.
// Depends on cta_pkg, cta_cell, cta_head and client_table_fanout_aging_assert.svh.
//
// Usage:
//   s_axis carries one sender address per transaction (tdata[31:0]).
//   m_axis returns the fan-out list for that frame: tdata holds dest_ip, tuser
//   holds dest_valid and sender_added, tlast marks the final result of the frame.
//   An empty fan-out yields one transaction with dest_valid low and tlast high.
//   cfg_we/cfg_wdata set the lifetime given on join or refresh; write only idle.
// Sequence:
//   After a transaction on s_axis, the MATCH state evaluates the table, then
//   the ring rotates one slot per cycle through all TABLE_ENTRIES slots, holding
//   while m_axis stalls, then the FLUSH state closes the frame.
//   s_axis_tready is high only between frames.
// Reset:
//   All slots empty, lifetime 1000, output stage empty.
// Backpressure:
//   When m_axis stalls, the ring holds its position and resumes without loss.
module client_table_fanout_aging
	import cta_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// sender_ip[31:0]
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// dest_ip[31:0]
	output logic [31:0] m_axis_tdata,
	// dest_valid[0], sender_added[1]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]        state_q;
	logic [LIFE_W-1:0] lifetime_q;
	logic [ADDR_W-1:0] sender_q;
	logic              added_q;
	logic              inserted_q;
	logic [IDX_W-1:0]  step_q;
	logic [CNT_W-1:0]  count_q;
	logic              held_valid_q;
	logic [ADDR_W-1:0] held_ip_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_ip_q;
	logic              out_dv_q;
	logic              out_added_q;
	logic              out_last_q;

	entry_t            cell_q   [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] match_vec;
	logic [TABLE_ENTRIES-1:0] free_vec;
	head_res_t         hd;

	logic s_fire;
	logic out_free;
	logic run_step;
	logic emit_ok;
	logic push_held;
	logic flush_go;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign run_step      = (state_q == ST_RUN) && out_free;
	assign emit_ok       = hd.emit && (count_q < CNT_W'(MAX_RESULTS));
	assign push_held     = run_step && emit_ok && held_valid_q;
	assign flush_go      = (state_q == ST_FLUSH) && out_free;

	// Ring of slots; the head slot wraps to the tail through the update logic
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		entry_t d_k;
		if (k == TABLE_ENTRIES - 1) begin : g_tail
			assign d_k = hd.nxt;
		end else begin : g_mid
			assign d_k = cell_q[k+1];
		end
		cta_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (run_step),
			.d      (d_k),
			.sender (sender_q),
			.q      (cell_q[k]),
			.match  (match_vec[k]),
			.free   (free_vec[k])
		);
	end

	cta_head u_head (
		.e        (cell_q[0]),
		.sender   (sender_q),
		.added    (added_q),
		.inserted (inserted_q),
		.lifetime (lifetime_q),
		.res      (hd)
	);

	// Lifetime register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_AT_RESET;
		end else if (cfg_we) begin
			lifetime_q <= cfg_wdata;
		end
	end

	// Sender capture
	always_ff @(posedge clk) begin
		if (s_fire) begin
			sender_q <= s_axis_tdata;
		end
	end

	// Frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			added_q      <= 1'b0;
			inserted_q   <= 1'b0;
			step_q       <= '0;
			count_q      <= '0;
			held_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q    <= ST_MATCH;
						inserted_q <= 1'b0;
						step_q     <= '0;
						count_q    <= '0;
					end
				end
				ST_MATCH: begin
					// new sender goes in only if unknown and a slot is free
					added_q <= (sender_q != '0) && !(|match_vec) && (|free_vec);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (run_step) begin
						if (hd.ins) begin
							inserted_q <= 1'b1;
						end
						if (emit_ok) begin
							held_valid_q <= 1'b1;
							count_q      <= count_q + CNT_W'(1);
						end
						if (step_q == IDX_W'(TABLE_ENTRIES - 1)) begin
							state_q <= ST_FLUSH;
						end
						step_q <= step_q + IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the latest destination until its successor or the frame end is known
	always_ff @(posedge clk) begin
		if (run_step && emit_ok) begin
			held_ip_q <= cell_q[0].addr;
		end
	end

	// Output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_held || flush_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (push_held) begin
			out_ip_q    <= held_ip_q;
			out_dv_q    <= 1'b1;
			out_added_q <= added_q;
			out_last_q  <= 1'b0;
		end else if (flush_go) begin
			out_ip_q    <= held_valid_q ? held_ip_q : '0;
			out_dv_q    <= held_valid_q;
			out_added_q <= added_q;
			out_last_q  <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_ip_q;
	assign m_axis_tuser  = {out_added_q, out_dv_q};
	assign m_axis_tlast  = out_last_q;

	`include "client_table_fanout_aging_assert.svh"

	`CTA_ASSERT_IMP(a_idle_no_held, state_q == ST_IDLE, !held_valid_q, "held result left between frames")
	`CTA_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_RESULTS), "result count overflow")
	`CTA_ASSERT_IMP(a_step_needs_room, run_step, !m_axis_tvalid || m_axis_tready, "ring stepped into a stalled output")
	`CTA_ASSERT_NXT(a_single_insert, run_step && hd.ins, inserted_q, "insert not recorded")

endmodule

@@ design/cta_cell.sv @@
// One slot of the rotating client table ring.
// Depends on cta_pkg for entry_t.
module cta_cell
	import cta_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  entry_t            d,
	input  logic [ADDR_W-1:0] sender,
	output entry_t            q,
	output logic              match,
	output logic              free
);

	entry_t entry_q;

	// Take the neighbor's slot on every ring step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q     = entry_q;
	assign free  = (entry_q.addr == '0);
	assign match = !free && (entry_q.addr == sender);

endmodule

@@ design/cta_head.sv @@
// Slot update at the head of the ring: insert, refresh, fan-out test, aging.
// Depends on cta_pkg for entry_t and head_res_t.
module cta_head
	import cta_pkg::*;
(
	input  entry_t            e,
	input  logic [ADDR_W-1:0] sender,
	input  logic              added,
	input  logic              inserted,
	input  logic [LIFE_W-1:0] lifetime,
	output head_res_t         res
);

	logic              was_free;
	logic              refresh;
	logic              ins;
	logic [ADDR_W-1:0] a1;
	logic [LIFE_W-1:0] l1;
	logic [LIFE_W-1:0] l2;

	always_comb begin
		was_free = (e.addr == '0);
		// first slot free before aging takes a new sender
		ins      = was_free && added && !inserted;
		refresh  = !was_free && (e.addr == sender);
		a1       = ins ? sender : e.addr;
		l1       = (ins || refresh) ? lifetime : e.life;
		l2       = l1 - LIFE_W'(1);

		res.nxt.addr = a1;
		res.nxt.life = l1;
		// age: a zero lifetime never counts down
		if (a1 != '0 && l1 != '0) begin
			res.nxt.life = l2;
			if (l2 == '0) begin
				res.nxt.addr = '0;
			end
		end
		res.emit = !was_free && (e.addr != sender);
		res.ins  = ins;
	end

endmodule
